### hdl/jdc_pkg.sv
// Package for the joystick to drive command block.
// Holds the command, message and state types, reset constants and the speed scaling function.
// No dependencies.
`default_nettype none

package jdc_pkg;

    localparam int unsigned SampleWidth = 8;
    localparam int unsigned PeriodWidth = 16;
    localparam int unsigned SpeedWidth  = 4;

    localparam logic [PeriodWidth-1:0] PeriodReset = 16'd500;

    // Steering zone limits. The straight and right zones overlap on purpose.
    localparam logic [SampleWidth-1:0] SteerStraightLow = 8'd21;
    localparam logic [SampleWidth-1:0] SteerLeftLow     = 8'd230;
    localparam logic [SampleWidth-1:0] SteerRightHigh   = 8'd30;

    // Throttle zone limits.
    localparam logic [SampleWidth-1:0] ThrottleReverseHigh = 8'd110;
    localparam logic [SampleWidth-1:0] ThrottleForwardLow  = 8'd145;

    localparam logic [SpeedWidth-1:0] SpeedMax = 4'd9;
    localparam int unsigned SpeedDivisor = 110;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_STEER    = 2'd1,
        CMD_THROTTLE = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        MSG_NOTICE   = 3'd0,
        MSG_STRAIGHT = 3'd1,
        MSG_LEFT     = 3'd2,
        MSG_RIGHT    = 3'd3,
        MSG_STOP     = 3'd4,
        MSG_FORWARD  = 3'd5,
        MSG_REVERSE  = 3'd6
    } msg_t;

    typedef enum logic [1:0] {
        STEER_STRAIGHT = 2'd0,
        STEER_LEFT     = 2'd1,
        STEER_RIGHT    = 2'd2
    } steer_t;

    typedef enum logic [1:0] {
        DRIVE_STOP    = 2'd0,
        DRIVE_FORWARD = 2'd1,
        DRIVE_REVERSE = 2'd2
    } drive_t;

    typedef struct packed {
        steer_t                 steer_last;
        drive_t                 drive_last;
        logic [SpeedWidth-1:0]  last_speed;
        logic [PeriodWidth-1:0] notice_elapsed;
    } jdc_state_t;

    typedef struct packed {
        logic                  emit;
        msg_t                  code;
        logic [SpeedWidth-1:0] speed;
    } jdc_result_t;

    // Floor of n / 110 for n up to 990, as a count of thresholds passed.
    function automatic logic [SpeedWidth-1:0] div_by_110(input logic [9:0] n);
        logic [SpeedWidth-1:0] q;
        q = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (n >= 10'(k * SpeedDivisor))
            begin
                q = q + 4'd1;
            end
        end
        return q;
    endfunction

endpackage

`default_nettype wire

### hdl/jdc_joy_if.sv
// Input channel carrying joystick transactions: a command and a raw sample.
// Depends on nothing but the widths of the work fields.
`default_nettype none

interface jdc_joy_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink   (input valid, input command, input sample, output ready);
endinterface

`default_nettype wire

### hdl/jdc_msg_if.sv
// Output channel carrying drive message transactions: a message code and a speed digit.
// Depends on nothing but the widths of the result fields.
`default_nettype none

interface jdc_msg_if;
    logic       valid;
    logic       ready;
    logic [2:0] message_code;
    logic [3:0] speed_digit;

    modport source (output valid, output message_code, output speed_digit, input ready);
    modport sink   (input valid, input message_code, input speed_digit, output ready);
endinterface

`default_nettype wire

### hdl/jdc_decode.sv
// Combinational decode of one joystick transaction against the stored state.
// Depends on jdc_pkg for the state, result and code types.
`default_nettype none

module jdc_decode (
    input  wire logic [1:0]                 command,
    input  wire logic [7:0]                 sample,
    input  wire logic [jdc_pkg::PeriodWidth-1:0] notice_period,
    input  wire jdc_pkg::jdc_state_t        state,
    output jdc_pkg::jdc_state_t             state_next,
    output jdc_pkg::jdc_result_t            result
);
    import jdc_pkg::*;

    logic [PeriodWidth-1:0] elapsed_inc;
    logic [SampleWidth-1:0] fwd_offset;
    logic [SpeedWidth-1:0]  fwd_speed;
    logic [SpeedWidth-1:0]  rev_speed;
    logic [SpeedWidth-1:0]  drv_speed;
    drive_t                 drv_dir;
    msg_t                   drv_code;

    assign fwd_offset = sample - ThrottleForwardLow;
    assign fwd_speed  = div_by_110(10'(fwd_offset) * 10'd9);
    assign rev_speed  = SpeedMax - div_by_110(10'(sample) * 10'd9);

    // The elapsed count saturates so a period at the top value never fires.
    assign elapsed_inc = (state.notice_elapsed == '1) ? state.notice_elapsed
                                                      : state.notice_elapsed + 16'd1;

    always_comb
    begin
        if (sample >= ThrottleForwardLow)
        begin
            drv_speed = fwd_speed;
            drv_dir   = DRIVE_FORWARD;
            drv_code  = MSG_FORWARD;
        end
        else
        begin
            drv_speed = rev_speed;
            drv_dir   = DRIVE_REVERSE;
            drv_code  = MSG_REVERSE;
        end
    end

    always_comb
    begin
        state_next   = state;
        result.emit  = 1'b0;
        result.code  = MSG_NOTICE;
        result.speed = state.last_speed;
        unique case (command)
            CMD_TICK:
            begin
                if (elapsed_inc > notice_period)
                begin
                    state_next.notice_elapsed = '0;
                    result.emit = 1'b1;
                    result.code = MSG_NOTICE;
                end
                else
                begin
                    state_next.notice_elapsed = elapsed_inc;
                end
            end
            CMD_STEER:
            begin
                // Straight is tried first, then left, then right.
                if (sample >= SteerStraightLow && sample < SteerLeftLow
                    && state.steer_last != STEER_STRAIGHT)
                begin
                    state_next.steer_last = STEER_STRAIGHT;
                    result.emit = 1'b1;
                    result.code = MSG_STRAIGHT;
                end
                else if (sample >= SteerLeftLow && state.steer_last != STEER_LEFT)
                begin
                    state_next.steer_last = STEER_LEFT;
                    result.emit = 1'b1;
                    result.code = MSG_LEFT;
                end
                else if (sample <= SteerRightHigh && state.steer_last != STEER_RIGHT)
                begin
                    state_next.steer_last = STEER_RIGHT;
                    result.emit = 1'b1;
                    result.code = MSG_RIGHT;
                end
            end
            CMD_THROTTLE:
            begin
                if (sample > ThrottleReverseHigh && sample < ThrottleForwardLow)
                begin
                    // Stop leaves the stored speed alone.
                    if (state.drive_last != DRIVE_STOP)
                    begin
                        state_next.drive_last = DRIVE_STOP;
                        result.emit  = 1'b1;
                        result.code  = MSG_STOP;
                        result.speed = '0;
                    end
                end
                else if (drv_speed != state.last_speed || drv_dir != state.drive_last)
                begin
                    state_next.drive_last = drv_dir;
                    state_next.last_speed = drv_speed;
                    result.emit  = 1'b1;
                    result.code  = drv_code;
                    result.speed = drv_speed;
                end
            end
            default:
            begin
                result.emit = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

### hdl/joystick_to_drive_command_top.sv
// Top level of the joystick to drive command block.
// Depends on jdc_pkg, jdc_joy_if, jdc_msg_if and jdc_decode.
//
// Usage:
//   The joy channel takes transactions of a command (tick, steering sample or
//   throttle sample) and an 8-bit sample. The msg channel delivers drive
//   messages, each a message code and a speed digit. A transaction gives at
//   most one message; most give none as steer and throttle send only on change.
//   The notice period is written through cfg_wr_en and cfg_wr_data; the user
//   must write it only while the block is idle; the block does not enforce it.
//   A message shows on msg the cycle after its joy transaction. One transaction
//   per cycle is sustained while the receiver keeps up; the state update and
//   classification fit in the single decode stage ahead of the output register.
//   joy.ready is high whenever the output register is empty or is being
//   drained in the same cycle, so a stalled receiver holds off new input only
//   while a message is waiting.
//   Reset clears the steering, drive, speed and tick state, sets the notice
//   period to 500 and empties the output register.
`default_nettype none

module joystick_to_drive_command_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    jdc_joy_if.sink                            joy,
    jdc_msg_if.source                          msg,
    input  wire logic                          cfg_wr_en,
    input  wire logic [jdc_pkg::PeriodWidth-1:0] cfg_wr_data
);
    import jdc_pkg::*;

    logic [PeriodWidth-1:0] period_reg;
    jdc_state_t             state_reg;
    jdc_state_t             state_next;
    jdc_result_t            result;
    logic                   out_valid_reg;
    msg_t                   out_code_reg;
    logic [SpeedWidth-1:0]  out_speed_reg;
    logic                   accept;

    assign joy.ready = !out_valid_reg || msg.ready;
    assign accept    = joy.valid && joy.ready;

    jdc_decode u_decode (
        .command       (joy.command),
        .sample        (joy.sample),
        .notice_period (period_reg),
        .state         (state_reg),
        .state_next    (state_next),
        .result        (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg               <= PeriodReset;
            state_reg.steer_last     <= STEER_STRAIGHT;
            state_reg.drive_last     <= DRIVE_STOP;
            state_reg.last_speed     <= '0;
            state_reg.notice_elapsed <= '0;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                period_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                state_reg <= state_next;
            end
            if (accept && result.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (msg.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && result.emit)
        begin
            out_code_reg  <= result.code;
            out_speed_reg <= result.speed;
        end
    end

    assign msg.valid        = out_valid_reg;
    assign msg.message_code = out_code_reg;
    assign msg.speed_digit  = out_speed_reg;

endmodule

`default_nettype wire

### hdl/jdc_checker.sv
// Port-level checker for the joystick to drive command block, with its bind.
// Depends on jdc_pkg for message codes and limits.
`default_nettype none

module jdc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       joy_valid,
    input wire logic       joy_ready,
    input wire logic       msg_valid,
    input wire logic       msg_ready,
    input wire logic [2:0] message_code,
    input wire logic [3:0] speed_digit
);
    import jdc_pkg::*;

    // A waiting message must hold until the receiver takes it.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid && !msg_ready |=> msg_valid && $stable(message_code) && $stable(speed_digit))
        else $error("message changed while stalled");

    // With no message pending the block must be able to take input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !msg_valid |-> joy_ready)
        else $error("input blocked with empty output register");

    // A message only appears in the cycle after an accepted input transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_valid) |-> $past(joy_valid && joy_ready))
        else $error("message without an input transaction");

    // Stop carries a zero speed, and no speed exceeds the top level.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_valid |-> speed_digit <= SpeedMax
                      && (message_code != MSG_STOP || speed_digit == '0))
        else $error("bad speed digit");

endmodule

bind joystick_to_drive_command_top jdc_checker u_jdc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .joy_valid    (joy.valid),
    .joy_ready    (joy.ready),
    .msg_valid    (msg.valid),
    .msg_ready    (msg.ready),
    .message_code (msg.message_code),
    .speed_digit  (msg.speed_digit)
);

`default_nettype wire

### dv/tb_joystick_to_drive_command_top.sv
// Self-checking testbench for joystick_to_drive_command_top: a directed table, then random
// phases at several notice periods, checked against an in-bench model of the encoder.
// Depends on jdc_pkg, jdc_joy_if, jdc_msg_if and the block itself.
`default_nettype none

module tb_joystick_to_drive_command_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jdc_pkg::*;

    localparam logic [1:0] CmdUnused = 2'd3;

    // Zone limits and scaling, kept apart from the package so that a wrong constant there shows.
    localparam int StraightLo = 21;
    localparam int LeftLo     = 230;
    localparam int RightHi    = 30;
    localparam int ReverseHi  = 110;
    localparam int ForwardLo  = 145;
    localparam int TopLevel   = 9;
    localparam int ScaleDiv   = 110;

    localparam logic [15:0] PeriodAtReset = 16'd500;
    localparam logic [15:0] CountTop      = 16'hFFFF;
    localparam int          HoldCycles    = 300;
    localparam int          ItemsPerPhase = 95;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cmd;
        logic [7:0]  sample;
        logic [15:0] period;
        logic        typed;
        jdc_result_t want;
    } dir_row_t;

    localparam jdc_result_t NoMsg = '{1'b0, MSG_NOTICE, 4'd0};

    // Rows with typed set carry the message read straight off the spec; the rest are predicted.
    localparam dir_row_t DirRows [28] = '{
        '{ROW_ITEM, CMD_STEER,    8'd128, 16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_STEER,    8'd255, 16'd0, 1'b1, '{1'b1, MSG_LEFT,     4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd25,  16'd0, 1'b1, '{1'b1, MSG_STRAIGHT, 4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd25,  16'd0, 1'b1, '{1'b1, MSG_RIGHT,    4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd0,   16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_STEER,    8'd230, 16'd0, 1'b1, '{1'b1, MSG_LEFT,     4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd229, 16'd0, 1'b1, '{1'b1, MSG_STRAIGHT, 4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd21,  16'd0, 1'b1, '{1'b1, MSG_RIGHT,    4'd0}},
        '{ROW_ITEM, CMD_STEER,    8'd30,  16'd0, 1'b1, '{1'b1, MSG_STRAIGHT, 4'd0}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd128, 16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_THROTTLE, 8'd255, 16'd0, 1'b1, '{1'b1, MSG_FORWARD,  4'd9}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd145, 16'd0, 1'b1, '{1'b1, MSG_FORWARD,  4'd0}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd144, 16'd0, 1'b1, '{1'b1, MSG_STOP,     4'd0}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd111, 16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_THROTTLE, 8'd110, 16'd0, 1'b1, '{1'b1, MSG_REVERSE,  4'd0}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd0,   16'd0, 1'b1, '{1'b1, MSG_REVERSE,  4'd9}},
        '{ROW_ITEM, CMD_STEER,    8'd20,  16'd0, 1'b1, '{1'b1, MSG_RIGHT,    4'd9}},
        '{ROW_ITEM, CmdUnused,    8'd255, 16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_TICK,     8'd0,   16'd0, 1'b1, NoMsg},
        '{ROW_CFG,  CMD_TICK,     8'd0,   16'd0, 1'b0, NoMsg},
        '{ROW_ITEM, CMD_TICK,     8'd0,   16'd0, 1'b1, '{1'b1, MSG_NOTICE,   4'd9}},
        '{ROW_CFG,  CMD_TICK,     8'd0,   16'd1, 1'b0, NoMsg},
        '{ROW_ITEM, CMD_TICK,     8'd255, 16'd0, 1'b1, NoMsg},
        '{ROW_ITEM, CMD_TICK,     8'd0,   16'd0, 1'b1, '{1'b1, MSG_NOTICE,   4'd9}},
        '{ROW_ITEM, CMD_THROTTLE, 8'd200, 16'd0, 1'b0, NoMsg},
        '{ROW_ITEM, CMD_STEER,    8'd255, 16'd0, 1'b0, NoMsg},
        '{ROW_ITEM, CMD_THROTTLE, 8'd60,  16'd0, 1'b0, NoMsg},
        '{ROW_ITEM, CMD_TICK,     8'd0,   16'd0, 1'b0, NoMsg}
    };

    localparam logic [7:0] ZoneMarks [13] = '{
        8'd0, 8'd20, 8'd21, 8'd29, 8'd30, 8'd31, 8'd110,
        8'd111, 8'd144, 8'd145, 8'd229, 8'd230, 8'd255
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    jdc_joy_if joy_ch ();
    jdc_msg_if msg_ch ();

    joystick_to_drive_command_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .joy         (joy_ch),
        .msg         (msg_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Encoder state as the bench sees it.
    steer_t      cur_steer;
    drive_t      cur_drive;
    logic [3:0]  cur_speed;
    logic [15:0] ticks_since_notice;
    logic [15:0] notice_period_q;

    jdc_result_t pending_msgs [$];

    int  fail_count    = 0;
    int  joy_accepted  = 0;
    int  msgs_checked  = 0;
    int  notices_seen  = 0;
    bit  no_idle       = 1'b0;
    bit  hold_req      = 1'b0;

    function automatic jdc_result_t predict_drive_msg(input logic [1:0] cmd,
                                                      input logic [7:0] x);
        jdc_result_t res;
        int          xi;
        int          lvl;
        drive_t      dir;
        msg_t        code;
        res = NoMsg;
        xi  = int'(x);
        case (cmd)
            CMD_TICK:
            begin
                if (ticks_since_notice != CountTop)
                begin
                    ticks_since_notice = ticks_since_notice + 16'd1;
                end
                if (ticks_since_notice > notice_period_q)
                begin
                    ticks_since_notice = '0;
                    res.emit  = 1'b1;
                    res.code  = MSG_NOTICE;
                    res.speed = cur_speed;
                end
            end
            CMD_STEER:
            begin
                // Straight is tried first, so the overlap with the right zone goes to
                // straight unless steering already points straight.
                if (xi >= StraightLo && xi < LeftLo && cur_steer != STEER_STRAIGHT)
                begin
                    cur_steer = STEER_STRAIGHT;
                    res.emit  = 1'b1;
                    res.code  = MSG_STRAIGHT;
                    res.speed = cur_speed;
                end
                else if (xi >= LeftLo && cur_steer != STEER_LEFT)
                begin
                    cur_steer = STEER_LEFT;
                    res.emit  = 1'b1;
                    res.code  = MSG_LEFT;
                    res.speed = cur_speed;
                end
                else if (xi <= RightHi && cur_steer != STEER_RIGHT)
                begin
                    cur_steer = STEER_RIGHT;
                    res.emit  = 1'b1;
                    res.code  = MSG_RIGHT;
                    res.speed = cur_speed;
                end
            end
            CMD_THROTTLE:
            begin
                if (xi > ReverseHi && xi < ForwardLo)
                begin
                    // Stop reports speed zero but keeps the stored level.
                    if (cur_drive != DRIVE_STOP)
                    begin
                        cur_drive = DRIVE_STOP;
                        res.emit  = 1'b1;
                        res.code  = MSG_STOP;
                        res.speed = 4'd0;
                    end
                end
                else
                begin
                    if (xi >= ForwardLo)
                    begin
                        lvl  = ((xi - ForwardLo) * TopLevel) / ScaleDiv;
                        dir  = DRIVE_FORWARD;
                        code = MSG_FORWARD;
                    end
                    else
                    begin
                        lvl  = TopLevel - (TopLevel * xi) / ScaleDiv;
                        dir  = DRIVE_REVERSE;
                        code = MSG_REVERSE;
                    end
                    if (lvl != int'(cur_speed) || dir != cur_drive)
                    begin
                        cur_speed = 4'(lvl);
                        cur_drive = dir;
                        res.emit  = 1'b1;
                        res.code  = code;
                        res.speed = 4'(lvl);
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    // Offers one transaction, waits for its acceptance and records what it should produce.
    task automatic send_joy(input logic [1:0] cmd, input logic [7:0] x,
                            input logic typed, input jdc_result_t want);
        jdc_result_t res;
        joy_ch.valid   <= 1'b1;
        joy_ch.command <= cmd;
        joy_ch.sample  <= x;
        @(posedge clk);
        while (!joy_ch.ready)
        begin
            @(posedge clk);
        end
        joy_accepted++;
        res = predict_drive_msg(cmd, x);
        if (typed)
        begin
            res = want;
        end
        if (res.emit)
        begin
            pending_msgs.push_back(res);
        end
        if (!no_idle && $urandom_range(99) < 12)
        begin
            joy_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // The period is only changed with the block idle and every message delivered.
    task automatic write_period(input logic [15:0] value);
        joy_ch.valid <= 1'b0;
        while (pending_msgs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en       <= 1'b0;
        notice_period_q  = value;
    endtask

    task automatic send_random_joy();
        logic [1:0] cmd;
        logic [7:0] x;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            cmd = CMD_TICK;
        end
        else if (pick < 60)
        begin
            cmd = CMD_STEER;
        end
        else if (pick < 95)
        begin
            cmd = CMD_THROTTLE;
        end
        else
        begin
            cmd = CmdUnused;
        end
        if ($urandom_range(99) < 30)
        begin
            x = ZoneMarks[$urandom_range(12)];
        end
        else
        begin
            x = 8'($urandom_range(255));
        end
        send_joy(cmd, x, 1'b0, NoMsg);
    endtask

    // Message receiver: random back-pressure, plus one long hold-off on request.
    initial
    begin
        msg_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                msg_ch.ready <= 1'b0;
                for (int c = 0; c < HoldCycles; c++)
                begin
                    @(posedge clk);
                end
            end
            msg_ch.ready <= no_idle || ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        jdc_result_t want;
        if (rst_n && msg_ch.valid && msg_ch.ready)
        begin
            msgs_checked++;
            if (msg_ch.message_code == MSG_NOTICE)
            begin
                notices_seen++;
            end
            if (pending_msgs.size() == 0)
            begin
                $display("%0t: unexpected message, code %0d speed %0d", $time,
                         msg_ch.message_code, msg_ch.speed_digit);
                fail_count++;
            end
            else
            begin
                want = pending_msgs.pop_front();
                if (msg_ch.message_code !== want.code)
                begin
                    $display("%0t: message_code expected %0d, actual %0d", $time,
                             want.code, msg_ch.message_code);
                    fail_count++;
                end
                if (msg_ch.speed_digit !== want.speed)
                begin
                    $display("%0t: speed_digit expected %0d, actual %0d", $time,
                             want.speed, msg_ch.speed_digit);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [15:0] phase_periods [6];
        int          sent;
        int          waited;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        joy_ch.valid   <= 1'b0;
        joy_ch.command <= CMD_TICK;
        joy_ch.sample  <= '0;
        cur_steer          = STEER_STRAIGHT;
        cur_drive          = DRIVE_STOP;
        cur_speed          = '0;
        ticks_since_notice = '0;
        notice_period_q    = PeriodAtReset;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DirRows[i])
        begin
            if (DirRows[i].kind == ROW_CFG)
            begin
                write_period(DirRows[i].period);
            end
            else
            begin
                send_joy(DirRows[i].cmd, DirRows[i].sample, DirRows[i].typed, DirRows[i].want);
            end
        end

        phase_periods[0] = 16'd1;
        phase_periods[1] = 16'($urandom_range(2, 6));
        phase_periods[2] = 16'd0;
        phase_periods[3] = 16'($urandom_range(7, 40));
        phase_periods[4] = 16'd60000;
        phase_periods[5] = PeriodAtReset;
        foreach (phase_periods[p])
        begin
            write_period(phase_periods[p]);
            // One phase holds the receiver off so the block backs up into its input.
            hold_req = (p == 2);
            no_idle  = (p == 3);
            sent = 0;
            while (sent < ItemsPerPhase)
            begin
                send_random_joy();
                if (joy_ch.command != CmdUnused)
                begin
                    sent++;
                end
            end
        end

        // Finish with the period at its top value, where no notice can come due.
        write_period(CountTop);
        no_idle = 1'b0;
        for (int t = 0; t < 20; t++)
        begin
            send_random_joy();
        end

        joy_ch.valid <= 1'b0;
        waited = 0;
        while (pending_msgs.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (pending_msgs.size() != 0)
        begin
            $display("%0t: %0d expected messages never arrived", $time, pending_msgs.size());
            fail_count++;
        end

        $display("Covered %0d joystick transactions and %0d drive messages (%0d notices),",
                 joy_accepted, msgs_checked, notices_seen);
        $display("with notice periods from zero up to the top value and one long stall.");
        if (fail_count == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Timed out waiting for the run to finish.");
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
hdl/jdc_pkg.sv
hdl/jdc_joy_if.sv
hdl/jdc_msg_if.sv
hdl/jdc_decode.sv
hdl/joystick_to_drive_command_top.sv
hdl/jdc_checker.sv
dv/tb_joystick_to_drive_command_top.sv
